>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the glob matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Invariant that holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cons)) \
    else $error("invariant failed");

`endif

>>> rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// Glob matcher package
// Register indexes, character codes and the case folding function.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int REG_BYTES  = 32;
  localparam int LEN_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd5;

  localparam logic [7:0] STAR_CHAR   = 8'h2A;
  localparam logic [7:0] QMARK_CHAR  = 8'h3F;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Folds ASCII upper case to lower case unless matching is case sensitive.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic case_sens);
    if (!case_sens && (c >= UPPER_A) && (c <= UPPER_Z)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

>>> rtl/wgm_in_if.sv
// ----------------------------------------------------------------------------
// Glob matcher input channel
// Valid/ready channel carrying one name byte and its end marker.
// ----------------------------------------------------------------------------
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

>>> rtl/wgm_out_if.sv
// ----------------------------------------------------------------------------
// Glob matcher result channel
// Valid/ready channel carrying one match flag per name.
// ----------------------------------------------------------------------------
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

>>> rtl/wgm_star_close.sv
// ----------------------------------------------------------------------------
// Star closure
// Extends a set of pattern positions across runs of star bytes, using a
// parallel prefix network so the depth grows with the log of the width.
// ----------------------------------------------------------------------------
module wgm_star_close #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] set_in,
  input  logic [WIDTH-2:0] star_in,
  output logic [WIDTH-1:0] set_out
);

  localparam int LEVELS = $clog2(WIDTH);

  // g: reached, p: whole span below is stars, so reach passes through.
  logic [WIDTH-1:0] g [LEVELS+1];
  logic [WIDTH-1:0] p [LEVELS+1];

  always_comb begin
    g[0] = set_in;
    p[0] = {star_in, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1 << l)]);
          p[l+1][i] = p[l][i] & p[l][i-(1 << l)];
        end else begin
          g[l+1][i] = g[l][i];
          p[l+1][i] = p[l][i];
        end
      end
    end
  end

  assign set_out = g[LEVELS];

endmodule

>>> rtl/wildcard_glob_match_top.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Matches names streamed byte by byte against a star/question-mark pattern.
// ----------------------------------------------------------------------------
// Usage: load the pattern words, the pattern length and the case flag through
// the cfg_ write port while no name is in flight. Then stream each name on
// in_ch, one byte per word, with last_byte set on its final byte. Every name
// holds at least one byte.
// One word on out_ch follows each name: matched is 1 when the whole name
// matches the whole pattern. Bytes without last_byte give no result.
// An accepted byte is registered in the input register, and the set of
// reachable pattern positions is updated when it leaves that register, where
// the result of a final byte is also loaded into the output register.
// Throughput: one byte per cycle, set by the combinational position update
// (two star closures around one lane compare per pattern position).
// When out_ch stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the held result is taken, and in_ch drops ready.
// Reset clears config and valid registers; only position zero is reachable.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_glob_match_top #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wgm_in_if.sink                             in_ch,
  wgm_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WIDTH    = PATTERN_MAX + 1;
  localparam int CAP      = (PATTERN_MAX < wgm_pkg::REG_BYTES) ? PATTERN_MAX
                                                                 : wgm_pkg::REG_BYTES;
  localparam int PB       = (PATTERN_MAX > wgm_pkg::REG_BYTES) ? PATTERN_MAX
                                                                 : wgm_pkg::REG_BYTES;
  localparam int PAT_BITS = PB * 8;
  localparam logic [WIDTH-1:0] START_SET = WIDTH'(1);

  // Configuration registers.
  logic [wgm_pkg::CFG_DATA_W-1:0] pattern_word_r [4];
  logic [wgm_pkg::LEN_W-1:0]      pattern_length_r;
  logic                           case_sensitive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        pattern_word_r[k] <= '0;
      end
      pattern_length_r <= '0;
      case_sensitive_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        wgm_pkg::REG_PATTERN_WORD_0, wgm_pkg::REG_PATTERN_WORD_1,
        wgm_pkg::REG_PATTERN_WORD_2, wgm_pkg::REG_PATTERN_WORD_3: begin
          pattern_word_r[cfg_index[1:0]] <= cfg_data;
        end
        wgm_pkg::REG_PATTERN_LENGTH: begin
          pattern_length_r <= cfg_data[wgm_pkg::LEN_W-1:0];
        end
        wgm_pkg::REG_CASE_SENSITIVE: begin
          case_sensitive_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register and handshake.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       in_acc;
  logic       out_valid_r;
  logic       out_matched_r;

  // Only a final byte needs room in the output register.
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // Pattern lanes.
  logic [PAT_BITS-1:0]       pat_ext;
  logic [7:0]                pb [PATTERN_MAX];
  logic [wgm_pkg::LEN_W-1:0] len_act;
  logic [PATTERN_MAX-1:0]    lane_on;
  logic [PATTERN_MAX-1:0]    star_m;
  logic [7:0]                c_fold;

  assign pat_ext = PAT_BITS'({pattern_word_r[3], pattern_word_r[2],
                              pattern_word_r[1], pattern_word_r[0]});
  assign len_act = (pattern_length_r > wgm_pkg::LEN_W'(CAP)) ? wgm_pkg::LEN_W'(CAP)
                                                             : pattern_length_r;
  assign c_fold  = wgm_pkg::fold_byte(s1_byte_r, case_sensitive_r);

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pb[j]      = pat_ext[8*j +: 8];
      lane_on[j] = len_act > wgm_pkg::LEN_W'(j);
      star_m[j]  = lane_on[j] && (pb[j] == wgm_pkg::STAR_CHAR);
    end
  end

  // Position set update: close, step one byte, close again.
  logic [WIDTH-1:0] reach_r;
  logic [WIDTH-1:0] pre_set;
  logic [WIDTH-1:0] step_set;
  logic [WIDTH-1:0] reach_nxt;
  logic             matched_nxt;

  wgm_star_close #(.WIDTH(WIDTH)) u_close_pre (
    .set_in  (reach_r),
    .star_in (star_m),
    .set_out (pre_set)
  );

  always_comb begin
    step_set = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (pre_set[j] && lane_on[j]) begin
        if (pb[j] == wgm_pkg::STAR_CHAR) begin
          step_set[j] = 1'b1;
        end else if ((pb[j] == wgm_pkg::QMARK_CHAR) ||
                     (wgm_pkg::fold_byte(pb[j], case_sensitive_r) == c_fold)) begin
          step_set[j+1] = 1'b1;
        end
      end
    end
  end

  wgm_star_close #(.WIDTH(WIDTH)) u_close_post (
    .set_in  (step_set),
    .star_in (star_m),
    .set_out (reach_nxt)
  );

  always_comb begin
    matched_nxt = 1'b0;
    for (int j = 0; j < WIDTH; j++) begin
      if ({1'b0, len_act} == 7'(j)) begin
        matched_nxt = reach_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= START_SET;
    end else if (s1_adv) begin
      reach_r <= s1_last_r ? START_SET : reach_nxt;
    end
  end

  // Output register.
  logic out_load;

  assign out_load = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched_r <= matched_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;

  // Checks.
  `ASSERT_NEXT(a_final_loads_out, clk, rst_n, out_load, out_valid_r)
  `ASSERT_NEXT(a_final_restarts, clk, rst_n, out_load, reach_r == START_SET)
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ch.ready,
               s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready)
  `ASSERT_ALWAYS(a_no_dead_bits, clk, rst_n, (reach_r >> (CAP + 1)) == '0)

endmodule
